FILE: sv/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg
// Shared sizes, request codes and control structs for the voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  // table sizes
  localparam int VOICES   = 16;
  localparam int CHANNELS = 16;

  // derived widths
  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);

  // fixed field widths
  localparam int TYPE_W     = 3;
  localparam int CHAN_W     = 4;
  localparam int PITCH_W    = 16;
  localparam int LEVEL_W    = 8;
  localparam int VIDX_W     = 4;
  localparam int OCNT_W     = 5;
  localparam int TIME_W     = 32;
  localparam int REL_W      = 24;
  localparam int CHAN_CMP_W = 8;

  // configuration port
  localparam int                 CFG_ADDR_W   = 3;
  localparam int                 CFG_DATA_W   = 32;
  localparam logic [REL_W-1:0]   REL_RESET    = REL_W'(4410);
  localparam logic               REG_RELEASE  = 1'b0;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_NONE     = 3'd0,
    REQ_NOTE_ON  = 3'd1,
    REQ_NOTE_OFF = 3'd2,
    REQ_END_ALL  = 3'd3,
    REQ_VOLUME   = 3'd4,
    REQ_TICK     = 3'd5,
    REQ_RSVD6    = 3'd6,
    REQ_RSVD7    = 3'd7
  } req_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;   // capture request, reset scan
    logic step;    // process one voice entry
    logic finish;  // load result register
  } sva_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;    // scan sits on the final voice
  } sva_stat_t;

endpackage

FILE: sv/synth_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit
// Polyphonic voice allocator: note on/off, end all, volume and tick events.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | req_type, channel, pitch, level
//  out     | out_valid/out_stall| status, voice_index, voices_touched,
//          |                    | active_voices
//  cfg     | APB psel/penable   | release_samples at byte address 0
//
//  each event captures the request, then reads and updates one voice table
//  entry per cycle, and finally loads the result register.
//  a finished result sits in the output register; the next event is taken
//  while it waits, and the load stalls only if the old result is still held.
//  synchronous active-low reset clears all voice flags, the sample counter
//  and sets release_samples to 4410.
// ----------------------------------------------------------------------------
module synth_voice_allocator_unit import sva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic [PITCH_W-1:0]    in_pitch,
  input  logic [LEVEL_W-1:0]    in_level,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_status,
  output logic [VIDX_W-1:0]     out_voice_index,
  output logic [OCNT_W-1:0]     out_voices_touched,
  output logic [OCNT_W-1:0]     out_active_voices,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  sva_cmd_t         cmd;
  sva_stat_t        stat;
  logic             rel_we;
  logic [REL_W-1:0] rel_samples;
  logic             reg_sel;

  // register decode, word addressed
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_RELEASE) && (paddr[1:0] == 2'b00);
  assign rel_we  = psel && penable && pwrite && pready &&
                   (paddr[CFG_ADDR_W-1:2] == REG_RELEASE);
  assign prdata  = reg_sel ? CFG_DATA_W'(rel_samples) : '0;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sva_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_channel         (in_channel),
    .in_pitch           (in_pitch),
    .in_level           (in_level),
    .rel_we             (rel_we),
    .rel_wdata          (pwdata[REL_W-1:0]),
    .rel_samples        (rel_samples),
    .out_status         (out_status),
    .out_voice_index    (out_voice_index),
    .out_voices_touched (out_voices_touched),
    .out_active_voices  (out_active_voices)
  );

endmodule

FILE: sv/sva_ctrl.sv
// ----------------------------------------------------------------------------
// sva_ctrl
// Sequencer: accepts a request, walks the voice table, hands off the result.
// ----------------------------------------------------------------------------
module sva_ctrl import sva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output sva_cmd_t  cmd,
  input  sva_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // result register free or draining this cycle
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // commands
  always_comb begin
    cmd.start  = (state_r == S_IDLE) && in_valid;
    cmd.step   = (state_r == S_SCAN);
    cmd.finish = (state_r == S_FINISH) && out_free;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken during a scan");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || !out_stall)
    else $error("result loaded over a stalled result");

  a_scan_leads_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && stat.last |=> state_r == S_FINISH)
    else $error("scan end did not reach finish");

endmodule

FILE: sv/sva_dp.sv
// ----------------------------------------------------------------------------
// sva_dp
// Voice table, sample counter and per-entry update logic, one voice a cycle.
// ----------------------------------------------------------------------------
module sva_dp import sva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sva_cmd_t              cmd,
  output sva_stat_t             stat,
  input  logic [TYPE_W-1:0]     in_req_type,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic [PITCH_W-1:0]    in_pitch,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic                  rel_we,
  input  logic [REL_W-1:0]      rel_wdata,
  output logic [REL_W-1:0]      rel_samples,
  output logic                  out_status,
  output logic [VIDX_W-1:0]     out_voice_index,
  output logic [OCNT_W-1:0]     out_voices_touched,
  output logic [OCNT_W-1:0]     out_active_voices
);

  // request capture
  req_e                 req_r;
  logic                 chan_ok_r;
  logic [CHAN_W-1:0]    chan_r;
  logic [PITCH_W-1:0]   pitch_r;
  logic [LEVEL_W-1:0]   level_r;

  // scan state
  logic [IDX_W-1:0]     idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [CNT_W-1:0]     touched_r;
  logic [CNT_W-1:0]     act_cnt_r;

  // voice table
  logic [VOICES-1:0]    active_r;
  logic [VOICES-1:0]    released_r;
  logic [CHAN_W-1:0]    chan_mem  [VOICES];
  logic [PITCH_W-1:0]   pitch_mem [VOICES];
  logic [LEVEL_W-1:0]   vol_mem   [VOICES];
  logic [TIME_W-1:0]    rstart_mem[VOICES];

  logic [TIME_W-1:0]    sample_time_r;
  logic [REL_W-1:0]     rel_r;

  // current entry
  logic                 v_act, v_rel, v_chan_eq, v_pitch_eq, v_expired;
  logic [TIME_W-1:0]    elapsed;
  logic                 hit_on, hit_off, hit_vol, hit_tick, hit;
  logic                 start_chan_ok;

  assign start_chan_ok = (CHAN_CMP_W'(in_channel) < CHAN_CMP_W'(CHANNELS));

  always_comb begin
    v_act      = active_r[idx_r];
    v_rel      = released_r[idx_r];
    v_chan_eq  = (chan_mem[idx_r] == chan_r);
    v_pitch_eq = (pitch_mem[idx_r] == pitch_r);
    elapsed    = sample_time_r - rstart_mem[idx_r];
    v_expired  = (elapsed > TIME_W'(rel_r));
    hit_on     = (req_r == REQ_NOTE_ON) && chan_ok_r && !found_r && !v_act;
    hit_off    = ((req_r == REQ_NOTE_OFF && v_pitch_eq) || req_r == REQ_END_ALL)
                 && chan_ok_r && v_act && !v_rel && v_chan_eq;
    hit_vol    = (req_r == REQ_VOLUME) && chan_ok_r && v_act && v_chan_eq;
    hit_tick   = (req_r == REQ_TICK) && v_act && v_rel && v_expired;
    hit        = hit_on || hit_off || hit_vol || hit_tick;
  end

  assign stat.last = (idx_r == IDX_W'(VOICES - 1));

  // control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= '0;
      released_r    <= '0;
      act_cnt_r     <= '0;
      sample_time_r <= '0;
      rel_r         <= REL_RESET;
      req_r         <= REQ_NONE;
      chan_ok_r     <= 1'b0;
      idx_r         <= '0;
      found_r       <= 1'b0;
      found_idx_r   <= '0;
      touched_r     <= '0;
    end else begin
      if (rel_we) begin
        rel_r <= rel_wdata;
      end
      if (cmd.start) begin
        req_r       <= req_e'(in_req_type);
        chan_ok_r   <= start_chan_ok;
        idx_r       <= '0;
        found_r     <= 1'b0;
        found_idx_r <= '0;
        touched_r   <= '0;
        if (req_e'(in_req_type) == REQ_TICK) begin
          sample_time_r <= sample_time_r + TIME_W'(1);
        end
      end else if (cmd.step) begin
        if (!stat.last) begin
          idx_r <= idx_r + IDX_W'(1);
        end
        if (hit) begin
          touched_r <= touched_r + CNT_W'(1);
        end
        if (hit_on) begin
          active_r[idx_r]   <= 1'b1;
          released_r[idx_r] <= 1'b0;
          found_r           <= 1'b1;
          found_idx_r       <= idx_r;
          act_cnt_r         <= act_cnt_r + CNT_W'(1);
        end
        if (hit_off) begin
          released_r[idx_r] <= 1'b1;
        end
        if (hit_tick) begin
          active_r[idx_r]   <= 1'b0;
          released_r[idx_r] <= 1'b0;
          act_cnt_r         <= act_cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // request payload and voice entry contents
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      chan_r  <= in_channel;
      pitch_r <= in_pitch;
      level_r <= in_level;
    end
    if (cmd.step) begin
      if (hit_on) begin
        chan_mem[idx_r]  <= chan_r;
        pitch_mem[idx_r] <= pitch_r;
      end
      if (hit_on || hit_vol) begin
        vol_mem[idx_r] <= level_r;
      end
      if (hit_off) begin
        rstart_mem[idx_r] <= sample_time_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status         <= (req_r == REQ_NOTE_ON) && chan_ok_r && !found_r;
      out_voice_index    <= VIDX_W'(found_idx_r);
      out_voices_touched <= OCNT_W'(touched_r);
      out_active_voices  <= OCNT_W'(act_cnt_r);
    end
  end

  assign rel_samples = rel_r;

  // checks
  a_count_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt_r == CNT_W'($countones(active_r)))
    else $error("active count out of step with voice flags");

  a_released_is_active: assert property (@(posedge clk) disable iff (!rst_n)
    (released_r & ~active_r) == '0)
    else $error("released voice not active");

  a_full_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && req_r == REQ_NOTE_ON && chan_ok_r && !found_r |-> &active_r)
    else $error("note on failed while a voice was free");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for synth_voice_allocator_unit. A scoreboard class
// keeps its own copy of the voice table, predicts one result per accepted
// event and compares each result transfer field by field. Stimulus is a
// short directed run followed by phases of random note traffic, each phase
// with its own release length written over the APB-style port.
// ----------------------------------------------------------------------------
module testbench import sva_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = VOICES + 2;
  localparam int PHASE_ITEMS   = 240;
  localparam int MAX_PRINTS    = 50;

  localparam logic [CFG_ADDR_W-1:0] REL_ADDR = CFG_ADDR_W'(4 * REG_RELEASE);

  typedef struct packed {
    req_e                kind;
    logic [CHAN_W-1:0]   chan;
    logic [PITCH_W-1:0]  pitch;
    logic [LEVEL_W-1:0]  level;
  } voice_req_t;

  typedef struct packed {
    logic                status;
    logic [VIDX_W-1:0]   idx;
    logic [OCNT_W-1:0]   touched;
    logic [OCNT_W-1:0]   active;
  } voice_result_t;

  // voice table predictor and result queue
  class voice_scoreboard;
    bit                  act    [VOICES];
    bit                  rel    [VOICES];
    logic [CHAN_W-1:0]   chan   [VOICES];
    logic [PITCH_W-1:0]  ptch   [VOICES];
    logic [LEVEL_W-1:0]  vol    [VOICES];
    logic [TIME_W-1:0]   t_rel  [VOICES];
    logic [TIME_W-1:0]   now;
    logic [REL_W-1:0]    release_len;
    voice_result_t       expected_q[$];
    int                  errors;
    int                  results_seen;

    function new();
      for (int v = 0; v < VOICES; v++) begin
        act[v]   = 1'b0;
        rel[v]   = 1'b0;
        chan[v]  = '0;
        ptch[v]  = '0;
        vol[v]   = '1;
        t_rel[v] = '0;
      end
      now          = '0;
      release_len  = REL_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_release(logic [REL_W-1:0] len);
      release_len = len;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted event to the table and queue its result
    function void note_request(voice_req_t r);
      voice_result_t e;
      int            touched;
      int            n_active;
      bit            chan_ok;
      bit            found;
      e       = '0;
      touched = 0;
      found   = 1'b0;
      chan_ok = (int'(r.chan) < CHANNELS);
      if (r.kind == REQ_NOTE_ON && chan_ok) begin
        e.status = 1'b1;
        for (int v = 0; v < VOICES; v++) begin
          if (!found && !act[v]) begin
            found    = 1'b1;
            act[v]   = 1'b1;
            rel[v]   = 1'b0;
            chan[v]  = r.chan;
            ptch[v]  = r.pitch;
            vol[v]   = r.level;
            e.status = 1'b0;
            e.idx    = VIDX_W'(v);
            touched  = 1;
          end
        end
      end else if ((r.kind == REQ_NOTE_OFF || r.kind == REQ_END_ALL) && chan_ok) begin
        for (int v = 0; v < VOICES; v++) begin
          if (act[v] && !rel[v] && chan[v] == r.chan &&
              (r.kind == REQ_END_ALL || ptch[v] == r.pitch)) begin
            rel[v]   = 1'b1;
            t_rel[v] = now;
            touched++;
          end
        end
      end else if (r.kind == REQ_VOLUME && chan_ok) begin
        for (int v = 0; v < VOICES; v++) begin
          if (act[v] && chan[v] == r.chan) begin
            vol[v] = r.level;
            touched++;
          end
        end
      end else if (r.kind == REQ_TICK) begin
        now = now + 1;
        for (int v = 0; v < VOICES; v++) begin
          if (act[v] && rel[v] && (TIME_W'(now - t_rel[v]) > TIME_W'(release_len))) begin
            act[v] = 1'b0;
            rel[v] = 1'b0;
            touched++;
          end
        end
      end
      n_active = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (act[v]) n_active++;
      end
      e.touched = OCNT_W'(touched);
      e.active  = OCNT_W'(n_active);
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("[tb] mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got_v, want_v);
      end
    endtask

    // compare one result transfer with the oldest prediction
    task check_result(voice_result_t got);
      voice_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no event pending", got, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.idx !== want.idx) report_mismatch("voice_index", got.idx, want.idx);
      if (got.touched !== want.touched) begin
        report_mismatch("voices_touched", got.touched, want.touched);
      end
      if (got.active !== want.active) begin
        report_mismatch("active_voices", got.active, want.active);
      end
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [TYPE_W-1:0]     in_req_type = '0;
  logic [CHAN_W-1:0]     in_channel  = '0;
  logic [PITCH_W-1:0]    in_pitch    = '0;
  logic [LEVEL_W-1:0]    in_level    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_status;
  logic [VIDX_W-1:0]     out_voice_index;
  logic [OCNT_W-1:0]     out_voices_touched;
  logic [OCNT_W-1:0]     out_active_voices;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  voice_scoreboard sb = new();
  voice_req_t      played_notes[$];
  bit              long_hold = 1'b0;
  int              cycle_count = 0;

  synth_voice_allocator_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_channel         (in_channel),
    .in_pitch           (in_pitch),
    .in_level           (in_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_voice_index    (out_voice_index),
    .out_voices_touched (out_voices_touched),
    .out_active_voices  (out_active_voices),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin
    voice_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status  = out_status;
      got.idx     = out_voice_index;
      got.touched = out_voices_touched;
      got.active  = out_active_voices;
      sb.check_result(got);
    end
  end

  // receiver stalls: mostly short, some long, some clean stretches
  initial begin
    int n;
    int pick;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 3);
        end else if (pick < 85) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (pick < 95) begin
          out_stall <= 1'b1;
          n = $urandom_range(4, 12);
        end else if (pick < 97) begin
          out_stall <= 1'b1;
          n = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b0;
          n = $urandom_range(50, 150);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic voice_req_t mk(req_e kind, logic [CHAN_W-1:0] chan,
                                    logic [PITCH_W-1:0] pitch, logic [LEVEL_W-1:0] level);
    voice_req_t r;
    r.kind  = kind;
    r.chan  = chan;
    r.pitch = pitch;
    r.level = level;
    return r;
  endfunction

  // random event: note on/off pairs on a few channels and pitches, plus noise
  function automatic voice_req_t make_event();
    voice_req_t r;
    voice_req_t prev;
    int         pick;
    r.chan  = ($urandom_range(0, 99) < 70) ? CHAN_W'($urandom_range(0, 3)) : CHAN_W'($urandom);
    r.level = LEVEL_W'($urandom);
    if ($urandom_range(0, 99) < 60) begin
      case ($urandom_range(0, 3))
        0:       r.pitch = 16'h0000;
        1:       r.pitch = 16'hFFFF;
        2:       r.pitch = 16'h5A5A;
        default: r.pitch = 16'h0123;
      endcase
    end else begin
      r.pitch = PITCH_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.kind = REQ_NOTE_ON;
      played_notes.push_back(r);
      if (played_notes.size() > 24) void'(played_notes.pop_front());
    end else if (pick < 50) begin
      r.kind = REQ_NOTE_OFF;
      if (played_notes.size() > 0 && $urandom_range(0, 9) < 8) begin
        prev    = played_notes[$urandom_range(0, played_notes.size() - 1)];
        r.chan  = prev.chan;
        r.pitch = prev.pitch;
      end
    end else if (pick < 57) begin
      r.kind = REQ_END_ALL;
    end else if (pick < 67) begin
      r.kind = REQ_VOLUME;
    end else if (pick < 93) begin
      r.kind = REQ_TICK;
    end else begin
      case ($urandom_range(0, 2))
        0:       r.kind = REQ_NONE;
        1:       r.kind = REQ_RSVD6;
        default: r.kind = REQ_RSVD7;
      endcase
    end
    return r;
  endfunction

  // offer one event and hold it until the transfer
  task automatic send_req(input voice_req_t r);
    in_valid    <= 1'b1;
    in_req_type <= r.kind;
    in_channel  <= r.chan;
    in_pitch    <= r.pitch;
    in_level    <= r.level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_release(data[REL_W-1:0]);
  endtask

  // read the release length back and compare its low bits
  task automatic cfg_readback(input logic [REL_W-1:0] want);
    logic [CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REL_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[REL_W-1:0] !== want) sb.report_mismatch("release_samples readback", rd, want);
  endtask

  // one random phase under a given release length
  task automatic run_phase(input logic [REL_W-1:0] rel_len, input int n_items,
                           input bit with_hold);
    int gap;
    int pick;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(REL_ADDR, CFG_DATA_W'(rel_len));
    // bus idle between the write and the read transfer
    @(posedge clk);
    cfg_readback(rel_len);
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) long_hold = 1'b1;
      send_req(make_event());
      pick = $urandom_range(0, 999);
      if (pick < 5) begin
        drain_results();
      end else begin
        if (pick < 600)      gap = 0;
        else if (pick < 900) gap = $urandom_range(1, 3);
        else if (pick < 980) gap = $urandom_range(4, 12);
        else                 gap = $urandom_range(20, 60);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    drain_results();
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_readback(REL_RESET);

    // directed: empty table, full table, no free voice, repeat release, noise
    send_req(mk(REQ_TICK, 4'h0, 16'h0000, 8'h00));
    send_req(mk(REQ_NOTE_OFF, 4'h0, 16'h0000, 8'h00));
    send_req(mk(REQ_VOLUME, 4'hF, 16'h0000, 8'h10));
    for (int v = 0; v < VOICES; v++) begin
      if (v == 0)      send_req(mk(REQ_NOTE_ON, 4'h0, 16'h0000, 8'h00));
      else if (v == 1) send_req(mk(REQ_NOTE_ON, 4'hF, 16'hFFFF, 8'hFF));
      else send_req(mk(REQ_NOTE_ON, CHAN_W'(v % 4), PITCH_W'(16'h0100 + v % 3),
                       LEVEL_W'(v * 16)));
    end
    send_req(mk(REQ_NOTE_ON, 4'h7, 16'h1234, 8'h55));
    send_req(mk(REQ_VOLUME, 4'h2, 16'h0000, 8'h80));
    send_req(mk(REQ_NOTE_OFF, 4'h0, 16'h0000, 8'h00));
    send_req(mk(REQ_NOTE_OFF, 4'h0, 16'h0000, 8'h00));
    send_req(mk(REQ_END_ALL, 4'h2, 16'h0000, 8'h00));
    send_req(mk(REQ_RSVD6, 4'h1, 16'hFFFF, 8'hFF));
    send_req(mk(REQ_RSVD7, 4'hF, 16'h0000, 8'h00));
    send_req(mk(REQ_NONE, 4'h3, 16'h5A5A, 8'hA5));
    send_req(mk(REQ_TICK, 4'hF, 16'hFFFF, 8'hFF));

    // random phases over several release lengths, extremes included
    run_phase(REL_W'(0), PHASE_ITEMS, 1'b0);
    run_phase(REL_W'(1), PHASE_ITEMS, 1'b1);
    run_phase(REL_W'($urandom_range(2, 40)), PHASE_ITEMS, 1'b0);
    run_phase(REL_W'(24'hFFFFFF), PHASE_ITEMS, 1'b0);
    run_phase(REL_W'(0), PHASE_ITEMS, 1'b1);
    run_phase(REL_RESET, PHASE_ITEMS, 1'b0);
    run_phase(REL_W'($urandom), PHASE_ITEMS, 1'b0);
    run_phase(REL_W'(3), PHASE_ITEMS, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sva_pkg.sv
sv/sva_ctrl.sv
sv/sva_dp.sv
sv/synth_voice_allocator_unit.sv
verif/testbench.sv
